// ----- hdl/a2d_pkg.sv -----
package a2d_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_FRAC      = 30;
  localparam int CORDIC_STEPS   = 24;
  localparam int TRIG_W         = 32;
  localparam int ZW             = 33;

  // CORDIC gain compensation, Q30
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

  typedef struct packed {
    logic signed [WORD_BITS_DEF-1:0]  pos_x;
    logic signed [WORD_BITS_DEF-1:0]  pos_y;
    logic        [ANGLE_BITS_DEF-1:0] angle;
    logic signed [WORD_BITS_DEF-1:0]  scale_x;
    logic signed [WORD_BITS_DEF-1:0]  scale_y;
    logic                             parent_present;
    logic signed [WORD_BITS_DEF-1:0]  par_m00;
    logic signed [WORD_BITS_DEF-1:0]  par_m01;
    logic signed [WORD_BITS_DEF-1:0]  par_m02;
    logic signed [WORD_BITS_DEF-1:0]  par_m10;
    logic signed [WORD_BITS_DEF-1:0]  par_m11;
    logic signed [WORD_BITS_DEF-1:0]  par_m12;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_BITS_DEF-1:0] loc_m00;
    logic signed [WORD_BITS_DEF-1:0] loc_m01;
    logic signed [WORD_BITS_DEF-1:0] loc_m10;
    logic signed [WORD_BITS_DEF-1:0] loc_m11;
    logic signed [WORD_BITS_DEF-1:0] out_m00;
    logic signed [WORD_BITS_DEF-1:0] out_m01;
    logic signed [WORD_BITS_DEF-1:0] out_m02;
    logic signed [WORD_BITS_DEF-1:0] out_m10;
    logic signed [WORD_BITS_DEF-1:0] out_m11;
    logic signed [WORD_BITS_DEF-1:0] out_m12;
  } out_word_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/a2d_cordic.sv -----
module a2d_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic        [a2d_pkg::ZW-2:0]          in_ang,
  output logic                                   out_vld,
  output logic signed [a2d_pkg::TRIG_W-1:0]      out_cos,
  output logic signed [a2d_pkg::TRIG_W-1:0]      out_sin
);
  import a2d_pkg::*;

  localparam int STAGES = CORDIC_STEPS / 4;

  logic                     vld_r [STAGES+1];
  logic signed [TRIG_W:0]   x_r   [STAGES+1];
  logic signed [TRIG_W:0]   y_r   [STAGES+1];
  logic signed [ZW-1:0]     z_r   [STAGES+1];
  logic [1:0]               q_r   [STAGES+1];
  logic [1:0]               q_nxt;
  logic [ZW-2:0]            r_nxt;

  // reduce to nearest quadrant
  always_comb begin
    q_nxt = 2'((in_ang + 32'h2000_0000) >> 30);
    r_nxt = in_ang - {q_nxt, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0] <= (TRIG_W+1)'(CORDIC_X0);
    y_r[0] <= '0;
    z_r[0] <= ZW'($signed(r_nxt));
    q_r[0] <= q_nxt;
  end

  // four micro-rotations per register stage
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [TRIG_W:0] xs [5];
    logic signed [TRIG_W:0] ys [5];
    logic signed [ZW-1:0]   zs [5];
    always_comb begin
      xs[0] = x_r[g];
      ys[0] = y_r[g];
      zs[0] = z_r[g];
      for (int k = 0; k < 4; k++) begin
        if (!zs[k][ZW-1]) begin
          xs[k+1] = xs[k] - (ys[k] >>> (g*4+k));
          ys[k+1] = ys[k] + (xs[k] >>> (g*4+k));
          zs[k+1] = zs[k] - atan_lut(5'(g*4+k));
        end else begin
          xs[k+1] = xs[k] + (ys[k] >>> (g*4+k));
          ys[k+1] = ys[k] - (xs[k] >>> (g*4+k));
          zs[k+1] = zs[k] + atan_lut(5'(g*4+k));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      x_r[g+1] <= xs[4];
      y_r[g+1] <= ys[4];
      z_r[g+1] <= zs[4];
      q_r[g+1] <= q_r[g];
    end
  end

  // map quadrant back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_r[STAGES];
    end
    case (q_r[STAGES])
      2'd0: begin
        out_cos <= TRIG_W'(x_r[STAGES]);
        out_sin <= TRIG_W'(y_r[STAGES]);
      end
      2'd1: begin
        out_cos <= TRIG_W'(-y_r[STAGES]);
        out_sin <= TRIG_W'(x_r[STAGES]);
      end
      2'd2: begin
        out_cos <= TRIG_W'(-x_r[STAGES]);
        out_sin <= TRIG_W'(-y_r[STAGES]);
      end
      default: begin
        out_cos <= TRIG_W'(y_r[STAGES]);
        out_sin <= TRIG_W'(-x_r[STAGES]);
      end
    endcase
  end

endmodule

// ----- hdl/a2d_rndsat.sv -----
module a2d_rndsat #(
  parameter int IN_W  = 67,
  parameter int SHIFT = 16,
  parameter int OUT_W = 32
) (
  input  logic signed [IN_W-1:0]  din,
  output logic signed [OUT_W-1:0] dout
);
  localparam logic signed [IN_W-1:0] HALF = IN_W'(1) <<< (SHIFT-1);
  localparam logic signed [IN_W-1:0] VMAX = IN_W'((64'sd1 <<< (OUT_W-1)) - 1);
  localparam logic signed [IN_W-1:0] VMIN = -VMAX - IN_W'(1);

  logic signed [IN_W:0] sum;
  logic signed [IN_W:0] shf;

  always_comb begin
    sum = (IN_W+1)'(din) + (IN_W+1)'(HALF);
    shf = sum >>> SHIFT;
    if (shf > (IN_W+1)'(VMAX)) begin
      dout = VMAX[OUT_W-1:0];
    end else if (shf < (IN_W+1)'(VMIN)) begin
      dout = VMIN[OUT_W-1:0];
    end else begin
      dout = shf[OUT_W-1:0];
    end
  end

endmodule

// ----- hdl/affine2d_transform_compose.sv -----
// Pipeline: 12 register stages: 1 quadrant fold, 6 CORDIC stages (4 micro-rotations
//   each), 1 quadrant map, 1 local multiply, 1 local round, 1 world multiply,
//   1 world sum, round and output register.
// Throughput: one word per cycle; busy is tied low since the receiver cannot stall.
// Reset: synchronous active-low rst_n clears every valid bit; data registers are
//   not reset.
module affine2d_transform_compose (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  a2d_pkg::in_word_t  in_word,
  output logic               out_vld,
  output a2d_pkg::out_word_t out_word
);
  import a2d_pkg::*;

  localparam int WORD_BITS  = WORD_BITS_DEF;
  localparam int ANGLE_BITS = ANGLE_BITS_DEF;
  localparam int FRAC = WORD_BITS / 2;
  localparam int PW   = WORD_BITS + TRIG_W;     // local product width
  localparam int WW   = 2 * WORD_BITS + 3;      // world sum width
  localparam int DLY  = 8;                     // CORDIC latency

  logic acc;
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // widen the angle to 32 bits per turn, ignore bits above ANGLE_BITS
  logic [ZW-2:0] ang32;
  assign ang32 = (ZW-1)'(in_word.angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);

  logic                      cs_vld;
  logic signed [TRIG_W-1:0]  cs_cos, cs_sin;

  a2d_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_ang  (ang32),
    .out_vld (cs_vld),
    .out_cos (cs_cos),
    .out_sin (cs_sin)
  );

  // hold the remaining fields alongside the CORDIC
  in_word_t dly_r [DLY];
  always_ff @(posedge clk) begin
    dly_r[0] <= in_word;
    for (int i = 1; i < DLY; i++) dly_r[i] <= dly_r[i-1];
  end

  in_word_t w_d;
  assign w_d = dly_r[DLY-1];

  // local products
  logic                  m1_vld_r;
  logic signed [PW-1:0]  p00_r, p01_r, p10_r, p11_r;
  in_word_t              m1_w_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= cs_vld;
    end
    p00_r  <= PW'($signed(w_d.scale_x[WORD_BITS-1:0])) * PW'(cs_cos);
    p01_r  <= -(PW'($signed(w_d.scale_x[WORD_BITS-1:0])) * PW'(cs_sin));
    p10_r  <= PW'($signed(w_d.scale_y[WORD_BITS-1:0])) * PW'(cs_sin);
    p11_r  <= PW'($signed(w_d.scale_y[WORD_BITS-1:0])) * PW'(cs_cos);
    m1_w_r <= w_d;
  end

  // round local entries
  logic signed [WORD_BITS-1:0] l00, l01, l10, l11;
  a2d_rndsat #(.IN_W(PW), .SHIFT(TRIG_FRAC), .OUT_W(WORD_BITS)) u_r00 (.din(p00_r), .dout(l00));
  a2d_rndsat #(.IN_W(PW), .SHIFT(TRIG_FRAC), .OUT_W(WORD_BITS)) u_r01 (.din(p01_r), .dout(l01));
  a2d_rndsat #(.IN_W(PW), .SHIFT(TRIG_FRAC), .OUT_W(WORD_BITS)) u_r10 (.din(p10_r), .dout(l10));
  a2d_rndsat #(.IN_W(PW), .SHIFT(TRIG_FRAC), .OUT_W(WORD_BITS)) u_r11 (.din(p11_r), .dout(l11));

  logic                         m2_vld_r;
  logic signed [WORD_BITS-1:0]  l00_r, l01_r, l10_r, l11_r;
  logic signed [WORD_BITS-1:0]  a00_r, a01_r, a02_r, a10_r, a11_r, a12_r;
  logic signed [WORD_BITS-1:0]  px_r, py_r;
  logic signed [WORD_BITS-1:0]  one_w;
  assign one_w = WORD_BITS'(1) <<< FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= m1_vld_r;
    end
    l00_r <= l00;
    l01_r <= l01;
    l10_r <= l10;
    l11_r <= l11;
    px_r  <= m1_w_r.pos_x[WORD_BITS-1:0];
    py_r  <= m1_w_r.pos_y[WORD_BITS-1:0];
    // absent parent: substitute identity
    if (m1_w_r.parent_present) begin
      a00_r <= m1_w_r.par_m00[WORD_BITS-1:0];
      a01_r <= m1_w_r.par_m01[WORD_BITS-1:0];
      a02_r <= m1_w_r.par_m02[WORD_BITS-1:0];
      a10_r <= m1_w_r.par_m10[WORD_BITS-1:0];
      a11_r <= m1_w_r.par_m11[WORD_BITS-1:0];
      a12_r <= m1_w_r.par_m12[WORD_BITS-1:0];
    end else begin
      a00_r <= one_w;
      a01_r <= '0;
      a02_r <= '0;
      a10_r <= '0;
      a11_r <= one_w;
      a12_r <= '0;
    end
  end

  // world products, registered before the sum
  logic                 m3_vld_r;
  logic signed [WW-1:0] q [12];
  logic signed [WW-1:0] q_r [12];
  logic signed [WORD_BITS-1:0] lq00_r, lq01_r, lq10_r, lq11_r;
  always_comb begin
    q[0]  = WW'(a00_r) * WW'(l00_r);
    q[1]  = WW'(a01_r) * WW'(l10_r);
    q[2]  = WW'(a00_r) * WW'(l01_r);
    q[3]  = WW'(a01_r) * WW'(l11_r);
    q[4]  = WW'(a00_r) * WW'(px_r);
    q[5]  = WW'(a01_r) * WW'(py_r);
    q[6]  = WW'(a10_r) * WW'(l00_r);
    q[7]  = WW'(a11_r) * WW'(l10_r);
    q[8]  = WW'(a10_r) * WW'(l01_r);
    q[9]  = WW'(a11_r) * WW'(l11_r);
    q[10] = WW'(a10_r) * WW'(px_r);
    q[11] = WW'(a11_r) * WW'(py_r);
  end

  logic signed [WW-1:0] t02, t12;
  assign t02 = WW'(a02_r) <<< FRAC;
  assign t12 = WW'(a12_r) <<< FRAC;

  logic signed [WW-1:0] tr02_r, tr12_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else begin
      m3_vld_r <= m2_vld_r;
    end
    for (int i = 0; i < 12; i++) q_r[i] <= q[i];
    tr02_r <= t02;
    tr12_r <= t12;
    lq00_r <= l00_r;
    lq01_r <= l01_r;
    lq10_r <= l10_r;
    lq11_r <= l11_r;
  end

  logic signed [WW-1:0] s00, s01, s02, s10, s11, s12;
  assign s00 = q_r[0] + q_r[1];
  assign s01 = q_r[2] + q_r[3];
  assign s02 = q_r[4] + q_r[5] + tr02_r;
  assign s10 = q_r[6] + q_r[7];
  assign s11 = q_r[8] + q_r[9];
  assign s12 = q_r[10] + q_r[11] + tr12_r;

  logic signed [WORD_BITS-1:0] w00, w01, w02, w10, w11, w12;
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w00 (.din(s00), .dout(w00));
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w01 (.din(s01), .dout(w01));
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w02 (.din(s02), .dout(w02));
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w10 (.din(s10), .dout(w10));
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w11 (.din(s11), .dout(w11));
  a2d_rndsat #(.IN_W(WW), .SHIFT(FRAC), .OUT_W(WORD_BITS)) u_w12 (.din(s12), .dout(w12));

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= m3_vld_r;
    end
    out_word.loc_m00 <= lq00_r;
    out_word.loc_m01 <= lq01_r;
    out_word.loc_m10 <= lq10_r;
    out_word.loc_m11 <= lq11_r;
    out_word.out_m00 <= w00;
    out_word.out_m01 <= w01;
    out_word.out_m02 <= w02;
    out_word.out_m10 <= w10;
    out_word.out_m11 <= w11;
    out_word.out_m12 <= w12;
  end

  // every accepted word leaves on out_vld after passing the whole register pipeline
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    ##12 (out_vld == $past(acc, 12)))
    else $error("latency mismatch");
  a_cs: assert property (@(posedge clk) disable iff (!rst_n)
    ##8 (cs_vld == $past(acc, 8)))
    else $error("cordic valid slip");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
